FILE: src/layer_blend_pixel_assert.svh
// Assertion macros shared by the layer blend pixel block.
`ifndef LAYER_BLEND_PIXEL_ASSERT_SVH
`define LAYER_BLEND_PIXEL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LBP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LBP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/lbp_pkg.sv
// Shared types, codes and fixed-point helpers of the layer blend pixel block.
package lbp_pkg;

   localparam logic [2:0] MODE_NORMAL   = 3'd0;
   localparam logic [2:0] MODE_ADD      = 3'd1;
   localparam logic [2:0] MODE_MULTIPLY = 3'd2;
   localparam logic [2:0] MODE_SCREEN   = 3'd3;
   localparam logic [2:0] MODE_OVERLAY  = 3'd4;

   localparam logic [1:0] CSR_LAYER_ENABLE = 2'd0;
   localparam logic [1:0] CSR_BLEND_MODE   = 2'd1;
   localparam logic [1:0] CSR_OPACITY      = 2'd2;

   // Load strobes of the four pipeline stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } lbp_adv_type;

   // Truncating division by 255 of a value below 2^17, with a single correction step.
   function automatic logic [8:0] div255(input logic [16:0] x);
      logic [17:0] est;
      logic [17:0] rem;
      logic [8:0]  q;
      est = ({1'b0, x} + {9'd0, x[16:8]}) >> 8;
      rem = {1'b0, x} - ((est << 8) - est);
      q   = est[8:0];
      if (rem >= 18'd255) begin
         q = q + 9'd1;
      end
      return q;
   endfunction

   function automatic logic [7:0] sat8(input logic [8:0] v);
      return v[8] ? 8'hff : v[7:0];
   endfunction

endpackage

FILE: src/lbp_lane.sv
// One color channel of the blend pipeline: mode product, blend, opacity mix, final divide.
module lbp_lane (
   input  logic               clock,
   input  lbp_pkg::lbp_adv_type adv,
   input  logic [2:0]         blend_mode,
   input  logic [7:0]         opacity,
   input  logic               bypass,
   input  logic [7:0]         base,
   input  logic [7:0]         fx,
   output logic [7:0]         result
);
   import lbp_pkg::*;

   logic [7:0]  mul_a;
   logic [7:0]  mul_b;
   logic [15:0] prod;
   logic [16:0] p1_in;
   logic [16:0] p1_ff;
   logic [7:0]  b1_ff;
   logic [7:0]  e1_ff;
   logic        byp1_ff;

   logic [8:0]  q2;
   logic [7:0]  q2_sat;
   logic [7:0]  bl2_in;
   logic [7:0]  bl2_ff;
   logic [7:0]  b2_ff;
   logic        byp2_ff;

   logic [7:0]  opacity_inv;
   logic [15:0] acc3_in;
   logic [15:0] acc3_ff;
   logic [7:0]  b3_ff;
   logic        byp3_ff;

   logic [8:0]  q4;
   logic [7:0]  result_in;
   logic [7:0]  result_ff;

   // Stage 1: one 8x8 product; screen and the upper overlay half use inverted operands.
   always_comb begin
      if (blend_mode == MODE_SCREEN || (blend_mode == MODE_OVERLAY && base[7])) begin
         mul_a = ~base;
         mul_b = ~fx;
      end else begin
         mul_a = base;
         mul_b = fx;
      end
      prod = mul_a * mul_b;
      case (blend_mode)
         MODE_ADD:      p1_in = 17'(base) + 17'(fx);
         MODE_MULTIPLY: p1_in = {1'b0, prod};
         MODE_SCREEN:   p1_in = {1'b0, prod};
         MODE_OVERLAY:  p1_in = {prod, 1'b0};
         default:       p1_in = 17'(fx);
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         p1_ff   <= p1_in;
         b1_ff   <= base;
         e1_ff   <= fx;
         byp1_ff <= bypass;
      end
   end

   // Stage 2: divide the product by 255 and form the blended value.
   always_comb begin
      q2     = div255(p1_ff);
      q2_sat = sat8(q2);
      case (blend_mode)
         MODE_ADD:      bl2_in = (p1_ff > 17'd255) ? 8'hff : p1_ff[7:0];
         MODE_MULTIPLY: bl2_in = q2_sat;
         MODE_SCREEN:   bl2_in = ~q2_sat;
         MODE_OVERLAY:  bl2_in = b1_ff[7] ? ~q2_sat : q2_sat;
         default:       bl2_in = e1_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         bl2_ff  <= bl2_in;
         b2_ff   <= b1_ff;
         byp2_ff <= byp1_ff;
      end
   end

   // Stage 3: opacity mix, base weighted by the inverse opacity (255 - opacity).
   assign opacity_inv = ~opacity;
   assign acc3_in     = (b2_ff * opacity_inv) + (opacity * bl2_ff);

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         acc3_ff <= acc3_in;
         b3_ff   <= b2_ff;
         byp3_ff <= byp2_ff;
      end
   end

   // Stage 4: final divide and the passthrough choice.
   always_comb begin
      q4        = div255({1'b0, acc3_ff});
      result_in = byp3_ff ? b3_ff : sat8(q4);
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

FILE: src/layer_blend_pixel.sv
// Top level of the layer blend pixel block: blends an effect RGBA pixel over a base pixel.
// Results leave in request order; one request per cycle unless the output stalls.
// The pace is set by the four-stage lane pipeline, each stage with its own valid bit.
// Reset is synchronous, active high: it empties the pipeline and restores the
// registers to enabled, normal mode and full opacity.
`include "layer_blend_pixel_assert.svh"
module layer_blend_pixel (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_base_red,
   input  logic [7:0] req_base_green,
   input  logic [7:0] req_base_blue,
   input  logic [7:0] req_base_alpha,
   input  logic [7:0] req_fx_red,
   input  logic [7:0] req_fx_green,
   input  logic [7:0] req_fx_blue,
   input  logic [7:0] req_fx_alpha,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic [7:0] rsp_out_alpha
);
   import lbp_pkg::*;

   // Configuration registers. The user must change them only while no request is in flight;
   // the block does not enforce this. Every stage but the last reads them directly.
   logic       layer_enable_ff;
   logic [2:0] blend_mode_ff;
   logic [7:0] opacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_enable_ff <= 1'b1;
         blend_mode_ff   <= MODE_NORMAL;
         opacity_ff      <= 8'hff;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LAYER_ENABLE: layer_enable_ff <= csr_write_data[0];
            CSR_BLEND_MODE:   blend_mode_ff   <= csr_write_data[2:0];
            CSR_OPACITY:      opacity_ff      <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Pipeline control. A stage may load when it is empty or when the stage
   // after it loads in the same cycle, so a stall at the output backs up one
   // stage at a time and the input keeps flowing until every stage is full.
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        v1_in, v2_in, v3_in, v4_in;
   lbp_adv_type adv;

   always_comb begin
      adv.s4 = !v4_ff || !rsp_stall;
      adv.s3 = !v3_ff || adv.s4;
      adv.s2 = !v2_ff || adv.s3;
      adv.s1 = !v1_ff || adv.s2;
      v1_in  = adv.s1 ? req_valid : v1_ff;
      v2_in  = adv.s2 ? v1_ff     : v2_ff;
      v3_in  = adv.s3 ? v2_ff     : v3_ff;
      v4_in  = adv.s4 ? v3_ff     : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign req_stall = !adv.s1;
   assign rsp_valid = v4_ff;

   // A disabled layer or zero opacity hands the base pixel through untouched.
   // Full opacity in normal mode needs no special path: the mix then yields
   // the effect value exactly.
   logic bypass;
   assign bypass = !layer_enable_ff || (opacity_ff == 8'd0);

   // Alpha does no arithmetic; the choice is made on entry and then rides
   // along with the color channels.
   logic [7:0] a1_in;
   logic [7:0] a1_ff, a2_ff, a3_ff, a4_ff;
   assign a1_in = bypass ? req_base_alpha : req_fx_alpha;

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         a1_ff <= a1_in;
      end
      if (adv.s2) begin
         a2_ff <= a1_ff;
      end
      if (adv.s3) begin
         a3_ff <= a2_ff;
      end
      if (adv.s4) begin
         a4_ff <= a3_ff;
      end
   end

   assign rsp_out_alpha = a4_ff;

   // One lane per color channel, all driven by the same load strobes.
   lbp_lane u_lane_red (
      .clock      (clock),
      .adv        (adv),
      .blend_mode (blend_mode_ff),
      .opacity    (opacity_ff),
      .bypass     (bypass),
      .base       (req_base_red),
      .fx         (req_fx_red),
      .result     (rsp_out_red)
   );

   lbp_lane u_lane_green (
      .clock      (clock),
      .adv        (adv),
      .blend_mode (blend_mode_ff),
      .opacity    (opacity_ff),
      .bypass     (bypass),
      .base       (req_base_green),
      .fx         (req_fx_green),
      .result     (rsp_out_green)
   );

   lbp_lane u_lane_blue (
      .clock      (clock),
      .adv        (adv),
      .blend_mode (blend_mode_ff),
      .opacity    (opacity_ff),
      .bypass     (bypass),
      .base       (req_base_blue),
      .fx         (req_fx_blue),
      .result     (rsp_out_blue)
   );

   // An accepted request must occupy the first stage in the next cycle.
   `LBP_ASSERT_NEXT(a_accept_fills_s1, req_valid && !req_stall, v1_ff,
      "accepted request did not enter the first stage")

   // With every stage full and the output stalled, no request may be taken.
   `LBP_ASSERT_NOW(a_full_blocks_input, v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall,
      req_stall, "request taken while the pipeline was full and stalled")

   // A delivered result with nothing behind it leaves the output stage empty.
   `LBP_ASSERT_NEXT(a_drain_empties_s4, v4_ff && !rsp_stall && !v3_ff, !v4_ff,
      "result repeated after delivery")

endmodule

FILE: verif/layer_blend_scoreboard.sv
// Pixel type and the scoreboard that predicts and checks blended pixels.
package layer_blend_tb_pkg;
   import lbp_pkg::*;

   typedef struct packed {
      bit [7:0] red;
      bit [7:0] green;
      bit [7:0] blue;
      bit [7:0] alpha;
   } rgba_pixel_type;

   class pixel_blend_scoreboard;
      localparam int unsigned MAX_REPORTS = 10;

      bit             layer_on;
      bit [2:0]       mode;
      bit [7:0]       opacity;
      rgba_pixel_type expected_pixels[$];
      int unsigned    errors;
      int unsigned    reported;

      function new();
         layer_on = 1'b1;
         mode     = MODE_NORMAL;
         opacity  = 8'hff;
         errors   = 0;
         reported = 0;
      endfunction

      // Bits above each register's width are dropped, as the block does.
      function void write_register(bit [1:0] index, bit [7:0] data);
         case (index)
            CSR_LAYER_ENABLE: layer_on = data[0];
            CSR_BLEND_MODE:   mode = data[2:0];
            CSR_OPACITY:      opacity = data;
            default: ;
         endcase
      endfunction

      function bit [7:0] blend_channel(int unsigned b, int unsigned e);
         int unsigned mixed;
         int unsigned op;
         op = opacity;
         case (mode)
            MODE_ADD:      mixed = (b + e > 255) ? 255 : b + e;
            MODE_MULTIPLY: mixed = (b * e) / 255;
            MODE_SCREEN:   mixed = 255 - ((255 - b) * (255 - e)) / 255;
            MODE_OVERLAY: begin
               if (b < 128) begin
                  mixed = (2 * b * e) / 255;
               end else begin
                  mixed = 255 - (2 * (255 - b) * (255 - e)) / 255;
               end
            end
            default:       mixed = e;
         endcase
         mixed = (b * (255 - op) + op * mixed) / 255;
         if (mixed > 255) begin
            mixed = 255;
         end
         return 8'(mixed);
      endfunction

      function rgba_pixel_type blend_pixel(rgba_pixel_type base, rgba_pixel_type fx);
         rgba_pixel_type result;
         if (!layer_on || opacity == 8'd0) begin
            return base;
         end
         if (opacity == 8'hff && mode == MODE_NORMAL) begin
            return fx;
         end
         result.red   = blend_channel(base.red, fx.red);
         result.green = blend_channel(base.green, fx.green);
         result.blue  = blend_channel(base.blue, fx.blue);
         result.alpha = fx.alpha;
         return result;
      endfunction

      function void note_request(rgba_pixel_type base, rgba_pixel_type fx);
         expected_pixels.push_back(blend_pixel(base, fx));
      endfunction

      function void check_response(rgba_pixel_type got);
         rgba_pixel_type want;
         if (expected_pixels.size() == 0) begin
            errors++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("ERROR: response %h arrived with no request pending", got);
            end
            return;
         end
         want = expected_pixels.pop_front();
         if (got.red != want.red || got.green != want.green ||
             got.blue != want.blue || got.alpha != want.alpha) begin
            errors++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("ERROR: rgba expected %h %h %h %h, got %h %h %h %h",
                        want.red, want.green, want.blue, want.alpha,
                        got.red, got.green, got.blue, got.alpha);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      function void flush_leftovers();
         if (expected_pixels.size() != 0) begin
            $display("ERROR: %0d responses never arrived", expected_pixels.size());
            errors += expected_pixels.size();
            expected_pixels.delete();
         end
      endfunction
   endclass

endpackage

FILE: verif/tb.sv
// Top-level testbench of the layer blend pixel block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lbp_pkg::*;
   import layer_blend_tb_pkg::*;

   // Cycles without any accepted request or response before the run is abandoned.
   // The longest legitimate quiet stretch is a settings change plus a random gap
   // or stall run, which stays far below this.
   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   // The pipeline is four stages deep; this covers it with margin.
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned RANDOM_SEGMENTS = 32;
   localparam int unsigned SEGMENT_ITEMS   = 50;
   // Index 3 has no register behind it; writes there must be ignored.
   localparam logic [1:0]  CSR_UNUSED      = 2'd3;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_base_red;
   logic [7:0] req_base_green;
   logic [7:0] req_base_blue;
   logic [7:0] req_base_alpha;
   logic [7:0] req_fx_red;
   logic [7:0] req_fx_green;
   logic [7:0] req_fx_blue;
   logic [7:0] req_fx_alpha;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;
   logic [7:0] rsp_out_alpha;

   // Percent chance per cycle that the sender holds back or the receiver stalls.
   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned quiet_cycles;

   pixel_blend_scoreboard sb;

   layer_blend_pixel dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_base_red     (req_base_red),
      .req_base_green   (req_base_green),
      .req_base_blue    (req_base_blue),
      .req_base_alpha   (req_base_alpha),
      .req_fx_red       (req_fx_red),
      .req_fx_green     (req_fx_green),
      .req_fx_blue      (req_fx_blue),
      .req_fx_alpha     (req_fx_alpha),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_alpha    (rsp_out_alpha)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver decides at each falling edge whether it stalls the next cycle.
   always @(negedge clock) begin
      rsp_stall = !reset && ($urandom_range(0, 99) < stall_pct);
   end

   // Both handshakes are observed at the rising edge, before the block updates.
   // A request is predicted the moment it is accepted, so the prediction always
   // uses the register values the block holds at that point.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            sb.note_request({req_base_red, req_base_green, req_base_blue, req_base_alpha},
                            {req_fx_red, req_fx_green, req_fx_blue, req_fx_alpha});
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_response({rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha});
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Ends the run if the block stops moving requests or responses.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
      end
      $display("DONE: errors detected");
      $finish;
   end

   function automatic rgba_pixel_type pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b,
                                            bit [7:0] a);
      return {r, g, b, a};
   endfunction

   // Bytes lean toward the ends of the range and toward the overlay split at 128.
   function automatic bit [7:0] random_byte();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return 8'd0;
         1:       return 8'hff;
         2:       return 8'($urandom_range(126, 129));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic rgba_pixel_type random_pixel();
      return pixel(random_byte(), random_byte(), random_byte(), random_byte());
   endfunction

   // Presents one request and holds it until the block takes it. Valid is left
   // high afterwards so back-to-back requests need no extra cycle.
   task automatic send_request(rgba_pixel_type base, rgba_pixel_type fx);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_base_red   = base.red;
      req_base_green = base.green;
      req_base_blue  = base.blue;
      req_base_alpha = base.alpha;
      req_fx_red     = fx.red;
      req_fx_green   = fx.green;
      req_fx_blue    = fx.blue;
      req_fx_alpha   = fx.alpha;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // Stops sending and waits until every request has come back, then lets the
   // pipeline settle so a register write cannot overlap work in flight.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [7:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      sb.write_register(index, data);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Writes all three registers; the unused upper data bits carry noise so the
   // block is seen to ignore them.
   task automatic apply_settings(bit layer_on, bit [2:0] mode, bit [7:0] opacity);
      wait_idle();
      write_csr(CSR_LAYER_ENABLE, {7'($urandom_range(0, 127)), layer_on});
      write_csr(CSR_BLEND_MODE, {5'($urandom_range(0, 31)), mode});
      write_csr(CSR_OPACITY, opacity);
   endtask

   task automatic random_settings();
      bit [2:0] mode;
      bit [7:0] opacity;
      int unsigned pick;
      // Mostly the defined modes, now and then the unused codes above overlay.
      if ($urandom_range(0, 9) < 8) begin
         mode = 3'($urandom_range(MODE_NORMAL, MODE_OVERLAY));
      end else begin
         mode = 3'($urandom_range(MODE_OVERLAY + 1, 7));
      end
      pick = $urandom_range(0, 7);
      case (pick)
         0:       opacity = 8'd0;
         1:       opacity = 8'hff;
         2:       opacity = 8'd1;
         3:       opacity = 8'hfe;
         default: opacity = 8'($urandom_range(0, 255));
      endcase
      apply_settings($urandom_range(0, 4) != 0, mode, opacity);
   endtask

   initial begin
      int unsigned idle_table[4];
      int unsigned stall_table[4];
      int unsigned phase;

      // Idling phases: none, sender gaps, receiver stalls, then both together.
      idle_table  = '{0, 71, 0, 34};
      stall_table = '{0, 0, 71, 34};

      sb               = new();
      idle_pct         = 0;
      stall_pct        = 0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_LAYER_ENABLE;
      csr_write_data   = 8'd0;
      req_valid        = 1'b0;
      req_base_red     = 8'd0;
      req_base_green   = 8'd0;
      req_base_blue    = 8'd0;
      req_base_alpha   = 8'd0;
      req_fx_red       = 8'd0;
      req_fx_green     = 8'd0;
      req_fx_blue      = 8'd0;
      req_fx_alpha     = 8'd0;

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Out of reset the layer is enabled, normal and fully opaque, so the
      // effect pixel should pass straight through.
      send_request(pixel(8'd0, 8'd0, 8'd0, 8'd0), pixel(8'hff, 8'hff, 8'hff, 8'hff));
      send_request(pixel(8'hff, 8'hff, 8'hff, 8'hff), pixel(8'd0, 8'd0, 8'd0, 8'd0));

      // A disabled layer hands back the base pixel, alpha included.
      apply_settings(1'b0, MODE_MULTIPLY, 8'd128);
      send_request(pixel(8'd12, 8'd34, 8'd56, 8'd78), pixel(8'd200, 8'd100, 8'd50, 8'd25));

      // Zero opacity does the same even when the layer is enabled.
      apply_settings(1'b1, MODE_SCREEN, 8'd0);
      send_request(pixel(8'd90, 8'd80, 8'd70, 8'd60), pixel(8'd1, 8'd2, 8'd3, 8'd4));

      // Each blending mode other than normal at full opacity. Red and green sit on either side of
      // the overlay split, and the extremes exercise add saturation.
      for (int m = MODE_ADD; m <= MODE_OVERLAY; m++) begin
         apply_settings(1'b1, 3'(m), 8'hff);
         send_request(pixel(8'd127, 8'd128, 8'hff, 8'd0), pixel(8'hff, 8'd200, 8'hff, 8'hff));
         send_request(pixel(8'd0, 8'hff, 8'd128, 8'hff), pixel(8'd0, 8'd0, 8'd129, 8'd17));
      end

      // Opacity one step from either end, normal mode.
      apply_settings(1'b1, MODE_NORMAL, 8'd1);
      send_request(pixel(8'hff, 8'd0, 8'd128, 8'd5), pixel(8'd0, 8'hff, 8'd127, 8'd250));
      apply_settings(1'b1, MODE_NORMAL, 8'hfe);
      send_request(pixel(8'hff, 8'd0, 8'd128, 8'd5), pixel(8'd0, 8'hff, 8'd127, 8'd250));

      // Every mode code at half opacity, including the unused ones that should
      // fall back to normal blending.
      for (int m = 0; m < 8; m++) begin
         apply_settings(1'b1, 3'(m), 8'd128);
         send_request(random_pixel(), random_pixel());
      end

      // A write to the unused index must leave the settings alone.
      wait_idle();
      write_csr(CSR_UNUSED, 8'($urandom_range(0, 255)));
      send_request(random_pixel(), random_pixel());

      // Random part: each segment picks new settings and streams pixels through
      // them, with the idling phase changing every quarter of the run.
      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         random_settings();
         phase     = seg * 4 / RANDOM_SEGMENTS;
         idle_pct  = idle_table[phase];
         stall_pct = stall_table[phase];
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            send_request(random_pixel(), random_pixel());
         end
      end

      wait_idle();
      sb.flush_leftovers();
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
